### hdl/cfd_pkg.sv
// Package for the camera FIFO frame decimator: field widths, codes,
// register map and the shared types. It depends on nothing else.
package cfd_pkg;

    localparam int DIM_W   = 12;
    localparam int LEN_W   = 23;
    localparam int BIL_W   = 13;
    localparam int LINE_W  = 24;
    localparam int OUT_W   = 25;
    localparam int IDX_W   = 3;
    localparam int DIVN_W  = DIM_W + 1;
    localparam int DIV_STEPS = DIVN_W;
    localparam int CNT_W   = $clog2(DIV_STEPS + 1);

    localparam logic [DIM_W-1:0] RST_SENSOR_WIDTH  = DIM_W'(320);
    localparam logic [DIM_W-1:0] RST_SENSOR_HEIGHT = DIM_W'(240);
    localparam logic [DIM_W-1:0] RST_TARGET_WIDTH  = DIM_W'(320);
    localparam logic [DIM_W-1:0] RST_TARGET_HEIGHT = DIM_W'(240);
    localparam logic [LEN_W-1:0] RST_FIFO_LIMIT    = LEN_W'(393215);

    typedef enum logic [IDX_W-1:0] {
        REG_SENSOR_WIDTH  = 3'd0,
        REG_SENSOR_HEIGHT = 3'd1,
        REG_TARGET_WIDTH  = 3'd2,
        REG_TARGET_HEIGHT = 3'd3,
        REG_FIFO_LIMIT    = 3'd4
    } cfg_reg_t;

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_FULL  = 2'd1,
        MODE_DECIM = 2'd2,
        MODE_CROP  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_OVERSIZE = 2'd1,
        STAT_EMPTY    = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_READY,
        ST_COL,
        ST_ROW
    } state_t;

    typedef struct packed {
        logic [DIM_W-1:0] sensor_width;
        logic [DIM_W-1:0] sensor_height;
        logic [DIM_W-1:0] target_width;
        logic [DIM_W-1:0] target_height;
        logic [LEN_W-1:0] fifo_limit;
    } cfg_t;

    typedef struct packed {
        logic              start;
        logic [DIVN_W-1:0] dividend;
        logic [DIM_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [DIVN_W-1:0] quotient;
    } div_rsp_t;

    // Step from the rounded-up ratio less one, but at least one.
    function automatic logic [DIM_W-1:0] step_fix(input logic [DIVN_W-1:0] q);
        logic [DIVN_W-1:0] qm;
        qm = q - DIVN_W'(1);
        if (q > DIVN_W'(1)) begin
            return qm[DIM_W-1:0];
        end
        return DIM_W'(1);
    endfunction

endpackage

### hdl/camera_fifo_frame_decimator_top.sv
// Top level of the camera FIFO frame decimator: stream ports, sequencer,
// byte datapath and result register. Depends on cfd_pkg, cfd_regs, cfd_div.
//
// Requests on the s_ channel are either a frame start (s_tuser low, byte
// count in s_tdata) or one FIFO byte (s_tuser high). Every request gives
// exactly one result on the m_ channel: the start status, or for a byte
// whether it is kept, its target write index, and m_tlast on the last byte
// of the frame's read pattern. Registers are written over the cfg_ channel,
// ready except while the divider works out the decimation steps; write them
// only while no request is outstanding, which the block does not enforce.
// A byte's result appears in the result register in the cycle after
// acceptance. A start that selects decimation runs the shared 13-step
// divider twice, for the column and the row step, so s_tready stays low
// until both steps are set; other starts leave the sequencer ready.
// While the receiver stalls, the result is held and no further request is
// accepted. Reset restores the register defaults, leaves no frame active
// and empties the result register.
module camera_fifo_frame_decimator_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,  // data_byte[7:0], fifo_length[30:8], zero
    input  logic        s_tuser,  // op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,  // status[1:0], pixel_byte[9:2],
                                  // write_index[34:10], zero
    output logic        m_tuser,  // keep
    output logic        m_tlast,  // frame_done
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [22:0] cfg_data
);
    import cfd_pkg::*;

    cfg_t     cfg;
    div_req_t div_req;
    div_rsp_t div_rsp;

    state_t state_reg, state_next;
    mode_t  mode_reg, mode_next;
    logic [DIM_W-1:0]  col_step_reg, col_step_next;
    logic [DIM_W-1:0]  row_step_reg, row_step_next;
    logic [BIL_W-1:0]  bil_reg, bil_next;
    logic [LINE_W-1:0] line_reg, line_next;
    logic [LINE_W-1:0] next_line_reg, next_line_next;
    logic [LINE_W-1:0] next_pair_reg, next_pair_next;
    logic [OUT_W-1:0]  out_count_reg, out_count_next;

    logic              m_valid_reg, m_valid_next;
    status_t           m_status_reg, m_status_next;
    logic              m_keep_reg, m_keep_next;
    logic [7:0]        m_byte_reg, m_byte_next;
    logic [OUT_W-1:0]  m_index_reg, m_index_next;
    logic              m_last_reg, m_last_next;

    logic              accept;
    logic              cfg_wr;
    logic [LEN_W-1:0]  len;
    logic [7:0]        in_byte;
    logic [DIM_W-1:0]  sw, sh, tw, th;
    logic [DIM_W-1:0]  min_w, min_h;
    logic [DIM_W-1:0]  pair;
    logic [LINE_W-1:0] pair_ext;
    logic [LINE_W-1:0] col_limit;
    logic [LINE_W-1:0] rows_decim;
    logic [LINE_W-1:0] lines_total;
    logic [BIL_W-1:0]  line_len;
    logic [BIL_W-1:0]  bil_inc;
    logic [LINE_W-1:0] line_inc;
    logic              decim;
    logic              on_line;
    logic              on_pair;
    logic              keep;
    logic              dims_ok;

    cfd_regs u_regs (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_wr),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    cfd_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign cfg_ready = (state_reg == ST_READY);
    assign cfg_wr    = cfg_valid && cfg_ready;

    assign sw      = cfg.sensor_width;
    assign sh      = cfg.sensor_height;
    assign tw      = cfg.target_width;
    assign th      = cfg.target_height;
    assign len     = s_tdata[30:8];
    assign in_byte = s_tdata[7:0];
    assign dims_ok = (sw != '0) && (sh != '0) && (tw != '0) && (th != '0);

    assign s_tready = (state_reg == ST_READY) && (!m_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;

    assign min_w      = (tw < sw) ? tw : sw;
    assign min_h      = (th < sh) ? th : sh;
    assign pair       = bil_reg[BIL_W-1:1];
    assign pair_ext   = {{(LINE_W-DIM_W){1'b0}}, pair};
    assign col_limit  = LINE_W'(tw) * LINE_W'(col_step_reg);
    assign rows_decim = LINE_W'(th) * LINE_W'(row_step_reg);
    assign decim      = (mode_reg == MODE_DECIM);
    assign on_line    = (line_reg == next_line_reg);
    assign on_pair    = (pair_ext == next_pair_reg);
    assign line_len   = {sw, 1'b0};
    assign bil_inc    = bil_reg + BIL_W'(1);
    assign line_inc   = line_reg + LINE_W'(1);
    assign lines_total = decim ? rows_decim : {{(LINE_W-DIM_W){1'b0}}, min_h};
    assign keep = decim ? (on_line && on_pair && (pair_ext < col_limit))
                        : (bil_reg < {min_w, 1'b0});

    always_comb begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        col_step_next  = col_step_reg;
        row_step_next  = row_step_reg;
        bil_next       = bil_reg;
        line_next      = line_reg;
        next_line_next = next_line_reg;
        next_pair_next = next_pair_reg;
        out_count_next = out_count_reg;

        m_valid_next  = m_valid_reg && !m_tready;
        m_status_next = m_status_reg;
        m_keep_next   = m_keep_reg;
        m_byte_next   = m_byte_reg;
        m_index_next  = m_index_reg;
        m_last_next   = m_last_reg;

        div_req.start    = 1'b0;
        div_req.dividend = {1'b0, sh} + {1'b0, th} - DIVN_W'(1);
        div_req.divisor  = th;
        if (state_reg == ST_READY) begin
            div_req.dividend = {1'b0, sw} + {1'b0, tw} - DIVN_W'(1);
            div_req.divisor  = tw;
        end

        unique case (state_reg)
            ST_READY: begin
                if (accept) begin
                    m_valid_next  = 1'b1;
                    m_status_next = STAT_OK;
                    m_keep_next   = 1'b0;
                    m_byte_next   = '0;
                    m_index_next  = '0;
                    m_last_next   = 1'b0;
                    if (!s_tuser) begin
                        mode_next      = MODE_IDLE;
                        col_step_next  = DIM_W'(1);
                        row_step_next  = DIM_W'(1);
                        bil_next       = '0;
                        line_next      = '0;
                        next_line_next = '0;
                        next_pair_next = '0;
                        out_count_next = '0;
                        priority if (len >= cfg.fifo_limit) begin
                            m_status_next = STAT_OVERSIZE;
                        end else if (len == '0) begin
                            m_status_next = STAT_EMPTY;
                        end else if (dims_ok) begin
                            priority if (tw >= sw) begin
                                mode_next = MODE_FULL;
                            end else if (th <= sh) begin
                                mode_next     = MODE_DECIM;
                                div_req.start = 1'b1;
                                state_next    = ST_COL;
                            end else begin
                                mode_next = MODE_CROP;
                            end
                        end
                    end else if (mode_reg != MODE_IDLE) begin
                        if (keep) begin
                            m_keep_next    = 1'b1;
                            m_byte_next    = in_byte;
                            m_index_next   = out_count_reg;
                            out_count_next = out_count_reg + OUT_W'(1);
                        end
                        if (decim && bil_reg[0] && on_pair) begin
                            next_pair_next = next_pair_reg
                                             + {{(LINE_W-DIM_W){1'b0}}, col_step_reg};
                        end
                        bil_next = bil_inc;
                        if (bil_inc >= line_len) begin
                            bil_next       = '0;
                            next_pair_next = '0;
                            if (decim && on_line) begin
                                next_line_next = next_line_reg
                                                 + {{(LINE_W-DIM_W){1'b0}}, row_step_reg};
                            end
                            line_next = line_inc;
                            if (line_inc >= lines_total) begin
                                m_last_next = 1'b1;
                                mode_next   = MODE_IDLE;
                            end
                        end
                    end
                end
            end
            ST_COL: begin
                if (div_rsp.done) begin
                    col_step_next = step_fix(div_rsp.quotient);
                    div_req.start = 1'b1;
                    state_next    = ST_ROW;
                end
            end
            ST_ROW: begin
                if (div_rsp.done) begin
                    row_step_next = step_fix(div_rsp.quotient);
                    state_next    = ST_READY;
                end
            end
            default: state_next = ST_READY;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_READY;
            mode_reg      <= MODE_IDLE;
            col_step_reg  <= DIM_W'(1);
            row_step_reg  <= DIM_W'(1);
            bil_reg       <= '0;
            line_reg      <= '0;
            next_line_reg <= '0;
            next_pair_reg <= '0;
            out_count_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            col_step_reg  <= col_step_next;
            row_step_reg  <= row_step_next;
            bil_reg       <= bil_next;
            line_reg      <= line_next;
            next_line_reg <= next_line_next;
            next_pair_reg <= next_pair_next;
            out_count_reg <= out_count_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_status_reg <= m_status_next;
        m_keep_reg   <= m_keep_next;
        m_byte_reg   <= m_byte_next;
        m_index_reg  <= m_index_next;
        m_last_reg   <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'b0, m_index_reg, m_byte_reg, m_status_reg};
    assign m_tuser  = m_keep_reg;
    assign m_tlast  = m_last_reg;

    logic unused_busy;
    assign unused_busy = div_rsp.busy & s_tdata[31];

endmodule

### hdl/cfd_regs.sv
// Configuration register bank of the camera FIFO frame decimator.
// Depends on cfd_pkg for the register map and the cfg_t struct.
module cfd_regs (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        wr_en,
    input  logic [cfd_pkg::IDX_W-1:0]   wr_index,
    input  logic [cfd_pkg::LEN_W-1:0]   wr_data,
    output cfd_pkg::cfg_t               cfg
);
    import cfd_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (wr_index)
                REG_SENSOR_WIDTH:  cfg_next.sensor_width  = wr_data[DIM_W-1:0];
                REG_SENSOR_HEIGHT: cfg_next.sensor_height = wr_data[DIM_W-1:0];
                REG_TARGET_WIDTH:  cfg_next.target_width  = wr_data[DIM_W-1:0];
                REG_TARGET_HEIGHT: cfg_next.target_height = wr_data[DIM_W-1:0];
                REG_FIFO_LIMIT:    cfg_next.fifo_limit    = wr_data;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sensor_width  <= RST_SENSOR_WIDTH;
            cfg_reg.sensor_height <= RST_SENSOR_HEIGHT;
            cfg_reg.target_width  <= RST_TARGET_WIDTH;
            cfg_reg.target_height <= RST_TARGET_HEIGHT;
            cfg_reg.fifo_limit    <= RST_FIFO_LIMIT;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### hdl/cfd_div.sv
// Shared restoring divider of the frame decimator, one quotient bit a cycle.
// Depends on cfd_pkg for widths and the request and response structs.
module cfd_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  cfd_pkg::div_req_t req,
    output cfd_pkg::div_rsp_t rsp
);
    import cfd_pkg::*;

    logic [CNT_W-1:0]  count_reg, count_next;
    logic              done_reg, done_next;
    logic [DIVN_W-1:0] num_reg, num_next;
    logic [DIM_W-1:0]  den_reg, den_next;
    logic [DIM_W-1:0]  rem_reg, rem_next;
    logic [DIVN_W-1:0] trial;
    logic [DIVN_W-1:0] diff;
    logic              fits;

    assign trial = {rem_reg, num_reg[DIVN_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign fits  = trial >= {1'b0, den_reg};

    always_comb begin
        count_next = count_reg;
        num_next   = num_reg;
        den_next   = den_reg;
        rem_next   = rem_reg;
        done_next  = 1'b0;
        if (req.start) begin
            count_next = CNT_W'(DIV_STEPS);
            num_next   = req.dividend;
            den_next   = req.divisor;
            rem_next   = '0;
        end else if (count_reg != '0) begin
            count_next = count_reg - CNT_W'(1);
            num_next   = {num_reg[DIVN_W-2:0], fits};
            rem_next   = fits ? diff[DIM_W-1:0] : trial[DIM_W-1:0];
            done_next  = (count_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end else begin
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
    end

    assign rsp.busy     = (count_reg != '0);
    assign rsp.done     = done_reg;
    assign rsp.quotient = num_reg;

endmodule
